>>> rtl/pli_pkg.sv
package pli_pkg;

  // Field widths (fixed by the stream format)
  localparam int CMD_W    = 2;
  localparam int POS_W    = 5;
  localparam int DIN_W    = 32;
  localparam int STAT_W   = 2;
  localparam int DOUT_W   = 32;
  localparam int CNTO_W   = 5;

  // Packed bus widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // Request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;   // perform the accepted request and load the result
  } ctrl_cmd_t;

endpackage

>>> rtl/pli_ctrl.sv
module pli_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output pli_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc;

  // A new item may enter whenever the result register is free or is being drained
  assign in_tready  = (state_r == S_IDLE) || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_HOLD);
  assign cmd.exec   = in_acc;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (in_acc) state_nxt = S_HOLD;
        else if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/pli_dp.sv
module pli_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pli_pkg::ctrl_cmd_t            cmd,
  input  logic [pli_pkg::CMD_W-1:0]     command,
  input  logic [pli_pkg::POS_W-1:0]     position,
  input  logic [pli_pkg::DIN_W-1:0]     data_in,
  output logic [pli_pkg::STAT_W-1:0]    status,
  output logic [pli_pkg::DOUT_W-1:0]    data_out,
  output logic [pli_pkg::CNTO_W-1:0]    count_out,
  output logic                          is_empty,
  output logic                          is_full
);

  // Stored element width: data field is 32 bits, so no more than that is kept
  localparam int ElemW = (DATA_WIDTH < pli_pkg::DIN_W) ? DATA_WIDTH : pli_pkg::DIN_W;
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CmpW  = (CntW > pli_pkg::POS_W) ? CntW : pli_pkg::POS_W;

  logic [ElemW-1:0]               cells_r   [DEPTH];
  logic [ElemW-1:0]               cells_nxt [DEPTH];
  logic [CntW-1:0]                count_r, count_nxt;
  logic [pli_pkg::STAT_W-1:0]     status_r, status_nxt;
  logic [pli_pkg::DOUT_W-1:0]     dout_r, dout_nxt;

  logic [CmpW-1:0]  pos_w, cnt_w;
  logic [ElemW-1:0] din_e, rd_data;
  logic             list_empty, list_full;
  logic             ins_ok, rem_ok, get_ok;

  assign din_e = data_in[ElemW-1:0];

  // Common-width copies of position and count for compares
  always_comb begin
    pos_w = '0;
    pos_w[pli_pkg::POS_W-1:0] = position;
    cnt_w = '0;
    cnt_w[CntW-1:0] = count_r;
  end

  assign list_empty = (count_r == '0);
  assign list_full  = (count_r == CntW'(DEPTH));
  assign rd_data    = cells_r[pos_w[IdxW-1:0]];

  // Request decode and status
  always_comb begin
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    get_ok     = 1'b0;
    status_nxt = pli_pkg::ST_OK;
    unique case (command)
      pli_pkg::CMD_INSERT: begin
        if (list_full) status_nxt = pli_pkg::ST_FULL;
        else if (pos_w > cnt_w) status_nxt = pli_pkg::ST_BADPOS;
        else ins_ok = 1'b1;
      end
      pli_pkg::CMD_REMOVE: begin
        if (list_empty) status_nxt = pli_pkg::ST_EMPTY;
        else if (pos_w >= cnt_w) status_nxt = pli_pkg::ST_BADPOS;
        else rem_ok = 1'b1;
      end
      pli_pkg::CMD_GET: begin
        if (list_empty) status_nxt = pli_pkg::ST_EMPTY;
        else if (pos_w >= cnt_w) status_nxt = pli_pkg::ST_BADPOS;
        else get_ok = 1'b1;
      end
      default: status_nxt = pli_pkg::ST_OK;  // unused command: no change
    endcase
  end

  // Count update and read data
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) count_nxt = CntW'(count_r + 1'b1);
    else if (rem_ok) count_nxt = CntW'(count_r - 1'b1);
    dout_nxt = '0;
    if (get_ok) dout_nxt[ElemW-1:0] = rd_data;
  end

  // Each cell picks its neighbor below (insert) or above (remove) in parallel
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CmpW-1:0] Pos = CmpW'(g);
    logic [ElemW-1:0] up_v, dn_v;

    if (g > 0) begin : g_up
      assign up_v = cells_r[g-1];
    end else begin : g_up0
      assign up_v = din_e;
    end

    if (g < DEPTH - 1) begin : g_dn
      assign dn_v = cells_r[g+1];
    end else begin : g_dnl
      assign dn_v = cells_r[g];
    end

    assign cells_nxt[g] = (ins_ok && (Pos > pos_w))  ? up_v  :
                          (ins_ok && (Pos == pos_w)) ? din_e :
                          (rem_ok && (Pos >= pos_w)) ? dn_v  : cells_r[g];
  end

  // Cell row and result payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cells_r  <= cells_nxt;
      status_r <= status_nxt;
      dout_r   <= dout_nxt;
    end
  end

  // Element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // Count and flags follow the stored count, which changes only with a new result
  assign status    = status_r;
  assign data_out  = dout_r;
  assign count_out = cnt_w[pli_pkg::CNTO_W-1:0];
  assign is_empty  = list_empty;
  assign is_full   = list_full;

endmodule

>>> rtl/positional_list_insert_remove.sv
// A result is shown in the cycle after its item is accepted.
// Throughput: one item per cycle unless the receiver stalls; every cell of the
// register row moves in parallel, so insert, remove and get each finish in the
// accepting cycle. The single result register is refilled in the cycle it is drained.
// Reset (rst_n low, synchronous) empties the list and drops out_tvalid;
// cell contents are not cleared and are never read before being written.
module positional_list_insert_remove #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pli_pkg::IN_TDATA_W-1:0]      in_tdata,   // position[4:0], data_in[36:5]
  input  logic [pli_pkg::CMD_W-1:0]           in_tuser,   // command[1:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pli_pkg::OUT_TDATA_W-1:0]     out_tdata   // status[1:0], data_out[33:2],
                                                          // count_out[38:34], is_empty[39],
                                                          // is_full[40]
);

  pli_pkg::ctrl_cmd_t             cmd;
  logic [pli_pkg::STAT_W-1:0]     status;
  logic [pli_pkg::DOUT_W-1:0]     data_out;
  logic [pli_pkg::CNTO_W-1:0]     count_out;
  logic                           is_empty, is_full;

  pli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pli_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .command   (in_tuser),
    .position  (in_tdata[4:0]),
    .data_in   (in_tdata[36:5]),
    .status    (status),
    .data_out  (data_out),
    .count_out (count_out),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

  // Pack result fields, zero pad to bytes
  assign out_tdata = {7'd0, is_full, is_empty, count_out, data_out, status};

endmodule

>>> rtl/pli_checker.sv
module pli_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pli_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted item shows a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  // Input is never blocked while no result is pending
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // Empty list reports zero count and is never also full
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39] |-> (out_tdata[38:34] == 5'd0) && !out_tdata[40])
    else $error("empty flag inconsistent with count or full flag");

endmodule

bind positional_list_insert_remove pli_checker u_pli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> dv/positional_list_insert_remove_tb.sv
`timescale 1ns / 1ps

module positional_list_insert_remove_tb;

  localparam int LIST_DEPTH  = 16;
  localparam int ELEM_W      = 32;
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake
  localparam int END_CYCLES  = 8;

  // Command code the block ignores (not part of cmd_t)
  localparam logic [pli_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    pli_pkg::status_t             status;
    logic [ELEM_W-1:0]            data;
    logic [pli_pkg::CNTO_W-1:0]   count;
    logic                         empty;
    logic                         full;
  } list_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [pli_pkg::IN_TDATA_W-1:0]  in_tdata = '0;    // position[4:0], data_in[36:5]
  logic [pli_pkg::CMD_W-1:0]       in_tuser = '0;    // command[1:0]
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [pli_pkg::OUT_TDATA_W-1:0] out_tdata;        // status[1:0], data_out[33:2],
                                                     // count_out[38:34], is_empty[39],
                                                     // is_full[40]

  // Shadow copy of the list, updated as each item is accepted
  logic [ELEM_W-1:0] list_cells [LIST_DEPTH];
  int                list_len;
  list_result_t      pending_list_results [$];
  list_result_t      oldest_result;

  int error_count;
  bit src_idle_en;
  bit sink_idle_en;
  bit long_hold_req;
  int hold_left;

  positional_list_insert_remove #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (ELEM_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Expected result of one request; updates the shadow list
  function automatic list_result_t predict_list_op(logic [pli_pkg::CMD_W-1:0] cmd,
                                                   logic [pli_pkg::POS_W-1:0] pos,
                                                   logic [ELEM_W-1:0] din);
    list_result_t r;
    r.status = pli_pkg::ST_OK;
    r.data   = '0;
    case (cmd)
      pli_pkg::CMD_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = pli_pkg::ST_FULL;
        end else if (int'(pos) > list_len) begin
          r.status = pli_pkg::ST_BADPOS;
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_cells[i] = list_cells[i-1];
          list_cells[pos] = din;
          list_len++;
        end
      end
      pli_pkg::CMD_REMOVE: begin
        if (list_len == 0) begin
          r.status = pli_pkg::ST_EMPTY;
        end else if (int'(pos) >= list_len) begin
          r.status = pli_pkg::ST_BADPOS;
        end else begin
          for (int i = int'(pos); i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      pli_pkg::CMD_GET: begin
        if (list_len == 0) begin
          r.status = pli_pkg::ST_EMPTY;
        end else if (int'(pos) >= list_len) begin
          r.status = pli_pkg::ST_BADPOS;
        end else begin
          r.data = list_cells[pos];
        end
      end
      default: ;  // unused command: no change
    endcase
    r.count = pli_pkg::CNTO_W'(list_len);
    r.empty = (list_len == 0);
    r.full  = (list_len == LIST_DEPTH);
    return r;
  endfunction

  task automatic log_error(string msg);
    error_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(string fname, longint unsigned want, longint unsigned got);
    if (want != got)
      log_error($sformatf("%s mismatch: expected %0h, actual %0h", fname, want, got));
  endtask

  // Send one item; a random gap may precede it. Valid stays high on return.
  task automatic send_item(logic [pli_pkg::CMD_W-1:0] cmd, logic [pli_pkg::POS_W-1:0] pos,
                           logic [ELEM_W-1:0] din);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(pli_pkg::IN_TDATA_W - ELEM_W - pli_pkg::POS_W){1'b0}}, din, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_list_results.push_back(predict_list_op(cmd, pos, din));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_list_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls and the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_list_results.size() == 0) begin
        log_error($sformatf("unexpected result: expected none, actual tdata %h", out_tdata));
      end else begin
        oldest_result = pending_list_results.pop_front();
        check_field("status",    oldest_result.status, out_tdata[1:0]);
        check_field("data_out",  oldest_result.data,   out_tdata[33:2]);
        check_field("count_out", oldest_result.count,  out_tdata[38:34]);
        check_field("is_empty",  oldest_result.empty,  out_tdata[39]);
        check_field("is_full",   oldest_result.full,   out_tdata[40]);
      end
    end
  end

  // Watchdog on handshake activity
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: watchdog expired, %0d results outstanding", $time,
             pending_list_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // Extremes, every command, error statuses, ignored command
  task automatic test_directed();
    send_item(pli_pkg::CMD_GET,    5'd0,  32'h1234_5678);
    send_item(pli_pkg::CMD_REMOVE, 5'd31, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED,          5'd0,  32'h0);
    send_item(pli_pkg::CMD_INSERT, 5'd1,  32'hDEAD_BEEF);  // past end of empty list
    send_item(pli_pkg::CMD_INSERT, 5'd0,  32'h0000_0000);
    send_item(pli_pkg::CMD_INSERT, 5'd0,  32'hFFFF_FFFF);  // at front
    send_item(pli_pkg::CMD_INSERT, 5'd2,  32'hA5A5_A5A5);  // at end
    send_item(pli_pkg::CMD_INSERT, 5'd1,  32'h5A5A_5A5A);  // in the middle
    send_item(pli_pkg::CMD_INSERT, 5'd31, 32'h0F0F_0F0F);
    for (int p = 0; p < 4; p++) send_item(pli_pkg::CMD_GET, 5'(p), 32'hFFFF_FFFF);
    send_item(pli_pkg::CMD_GET,    5'd4,  32'h0);
    send_item(pli_pkg::CMD_GET,    5'd31, 32'h0);
    send_item(pli_pkg::CMD_REMOVE, 5'd4,  32'h0);
    send_item(CMD_UNUSED,          5'd31, 32'hFFFF_FFFF);
    send_item(pli_pkg::CMD_REMOVE, 5'd1,  32'h0);
    send_item(pli_pkg::CMD_REMOVE, 5'd2,  32'h0);           // last element
    send_item(pli_pkg::CMD_REMOVE, 5'd0,  32'h0);
    send_item(pli_pkg::CMD_GET,    5'd0,  32'h0);
    send_item(pli_pkg::CMD_REMOVE, 5'd0,  32'h0);           // back to empty
    send_item(pli_pkg::CMD_GET,    5'd0,  32'h0);
  endtask

  // Fill to full, poke the full list, then drain to empty
  task automatic test_fill_and_drain();
    while (list_len < LIST_DEPTH)
      send_item(pli_pkg::CMD_INSERT, 5'($urandom_range(0, list_len)), $urandom);
    send_item(pli_pkg::CMD_INSERT, 5'd0,  $urandom);
    send_item(pli_pkg::CMD_INSERT, 5'd16, $urandom);
    send_item(pli_pkg::CMD_INSERT, 5'd31, $urandom);
    send_item(pli_pkg::CMD_GET,    5'd15, 32'h0);
    send_item(pli_pkg::CMD_GET,    5'd16, 32'h0);
    send_item(CMD_UNUSED,          5'd7,  $urandom);
    while (list_len > 0) begin
      send_item(pli_pkg::CMD_GET,    5'($urandom_range(0, list_len - 1)), $urandom);
      send_item(pli_pkg::CMD_REMOVE, 5'($urandom_range(0, list_len - 1)), $urandom);
    end
    send_item(pli_pkg::CMD_REMOVE, 5'd0, 32'h0);
  endtask

  // Random requests; mostly valid positions, some anywhere in range
  task automatic run_random_ops(int n, int ins_pct, int rem_pct);
    int sel;
    logic [pli_pkg::CMD_W-1:0] cmd;
    logic [pli_pkg::POS_W-1:0] pos;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < ins_pct) cmd = pli_pkg::CMD_INSERT;
      else if (sel < ins_pct + rem_pct) cmd = pli_pkg::CMD_REMOVE;
      else if (sel < 96) cmd = pli_pkg::CMD_GET;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 99) < 15 || (cmd != pli_pkg::CMD_INSERT && list_len == 0))
        pos = 5'($urandom_range(0, 31));
      else if (cmd == pli_pkg::CMD_INSERT)
        pos = 5'($urandom_range(0, list_len));
      else
        pos = 5'($urandom_range(0, list_len - 1));
      send_item(cmd, pos, $urandom);
    end
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_receiver_hold();
    src_idle_en   = 1'b0;
    long_hold_req = 1'b1;
    run_random_ops(40, 45, 25);
    src_idle_en   = 1'b1;
  endtask

  // Sender waits for every result before continuing
  task automatic test_sender_pause();
    wait_drained();
    run_random_ops(30, 40, 30);
  endtask

  // Swing between full and empty under random idling
  task automatic test_full_empty_swings();
    run_random_ops(120, 70, 15);
    run_random_ops(120, 15, 70);
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_streaming_no_idle();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random_ops(100, 45, 40);
  endtask

  initial begin
    error_count  = 0;
    list_len     = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    run_random_ops(200, 40, 30);
    test_receiver_hold();
    test_sender_pause();
    test_full_empty_swings();
    test_streaming_no_idle();

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (pending_list_results.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_list_results.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> positional_list_insert_remove.f
rtl/pli_pkg.sv
rtl/pli_ctrl.sv
rtl/pli_dp.sv
rtl/positional_list_insert_remove.sv
rtl/pli_checker.sv
dv/positional_list_insert_remove_tb.sv
